### sv/pid_regulator_filtered_derivative_core_assert.svh
// Assertion macros shared by the checker of the PID regulator core.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef PID_REGULATOR_FILTERED_DERIVATIVE_CORE_ASSERT_SVH
`define PID_REGULATOR_FILTERED_DERIVATIVE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRFD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prfd: same-cycle port property violated");

// Next-cycle implication, disabled while reset is asserted.
`define PRFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prfd: next-cycle port property violated");

`endif

### sv/prfd_pkg.sv
// Shared types, widths, microcode and arithmetic helpers of the PID regulator core.
// Used by prfd_sequencer, prfd_datapath and the top level; depends on nothing.
package prfd_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned COEF_W     = 24;
  localparam int unsigned POLE_W     = 17;
  localparam int unsigned CTRL_W     = 24;
  localparam int unsigned ERR_W      = 17;
  localparam int unsigned TERM_W     = 48;
  localparam int unsigned OPA_W      = 49;
  localparam int unsigned ACC_W      = 68;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned NUM_DIGITS = COEF_W / DIGIT_W;
  localparam int unsigned DCNT_W     = 2;
  localparam int unsigned PP_W       = OPA_W + DIGIT_W + 1;
  localparam int unsigned PC_W       = 4;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [DCNT_W-1:0] LAST_DIGIT = DCNT_W'(NUM_DIGITS - 1);

  // Reset values of the coefficient registers.
  localparam logic [COEF_W-1:0] GAIN_K_RST   = COEF_W'(65536);
  localparam logic [COEF_W-1:0] SP_WEIGHT_RST = COEF_W'(65536);
  localparam logic [COEF_W-1:0] INT_COEF_RST = COEF_W'(32768);
  localparam logic [POLE_W-1:0] POLE_RST     = POLE_W'(32768);
  localparam logic [COEF_W-1:0] D_GAIN_RST   = COEF_W'(32768);

  // Microprogram addresses that serve as jump targets.
  localparam logic [PC_W-1:0] PC_START  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_MAC_B  = PC_W'(1);
  localparam logic [PC_W-1:0] PC_MAC_K  = PC_W'(4);
  localparam logic [PC_W-1:0] PC_MAC_KI = PC_W'(7);
  localparam logic [PC_W-1:0] PC_MAC_AD = PC_W'(9);
  localparam logic [PC_W-1:0] PC_MAC_BD = PC_W'(11);
  localparam logic [PC_W-1:0] PC_COMMIT = PC_W'(15);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ENABLE    = 3'd0,
    REG_GAIN_K    = 3'd1,
    REG_SP_WEIGHT = 3'd2,
    REG_INT_COEF  = 3'd3,
    REG_D_POLE    = 3'd4,
    REG_D_GAIN    = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ACC_NOP, ACC_CLR, ACC_MAC, ACC_SUBY, ACC_SHRSAT,
    ACC_LOADI, ACC_LOADP, ACC_ADDI, ACC_ADDD
  } acc_op_e;

  typedef enum logic [2:0] {
    OPA_HOLD, OPA_SETP, OPA_ACC, OPA_E, OPA_DY, OPA_PREVD
  } opa_src_e;

  typedef enum logic [2:0] {
    COEF_B, COEF_K, COEF_KI, COEF_AD, COEF_BD
  } coef_sel_e;

  typedef enum logic [2:0] {
    ST_NONE, ST_P, ST_I, ST_D, ST_COMMIT
  } store_sel_e;

  typedef enum logic [1:0] {
    JMP_NONE, JMP_IF_DIS, JMP_LOOP, JMP_END
  } jmp_e;

  typedef struct packed {
    acc_op_e          acc_op;
    opa_src_e         opa_src;
    coef_sel_e        coef_sel;
    store_sel_e       store;
    jmp_e             jmp;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic              go;
    logic [DCNT_W-1:0] digit;
    uword_t            word;
  } seq_ctrl_t;

  typedef struct packed {
    logic              enable;
    logic [COEF_W-1:0] k;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] ki;
    logic [POLE_W-1:0] ad;
    logic [COEF_W-1:0] bd;
  } coef_t;

  function automatic uword_t mk(input acc_op_e a, input opa_src_e o, input coef_sel_e c,
                                input store_sel_e s, input jmp_e j,
                                input logic [PC_W-1:0] t);
    uword_t w;
    w.acc_op   = a;
    w.opa_src  = o;
    w.coef_sel = c;
    w.store    = s;
    w.jmp      = j;
    w.target   = t;
    return w;
  endfunction

  // Control store. Each multiply step repeats once per coefficient byte.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = mk(ACC_NOP, OPA_HOLD, COEF_B, ST_NONE, JMP_NONE, PC_START);
    case (pc)
      4'd0:  w = mk(ACC_CLR,    OPA_SETP,  COEF_B,  ST_NONE,   JMP_IF_DIS, PC_COMMIT);
      4'd1:  w = mk(ACC_MAC,    OPA_HOLD,  COEF_B,  ST_NONE,   JMP_LOOP,   PC_MAC_B);
      4'd2:  w = mk(ACC_SUBY,   OPA_HOLD,  COEF_B,  ST_NONE,   JMP_NONE,   PC_START);
      4'd3:  w = mk(ACC_CLR,    OPA_ACC,   COEF_B,  ST_NONE,   JMP_NONE,   PC_START);
      4'd4:  w = mk(ACC_MAC,    OPA_HOLD,  COEF_K,  ST_NONE,   JMP_LOOP,   PC_MAC_K);
      4'd5:  w = mk(ACC_SHRSAT, OPA_HOLD,  COEF_B,  ST_NONE,   JMP_NONE,   PC_START);
      4'd6:  w = mk(ACC_LOADI,  OPA_E,     COEF_B,  ST_P,      JMP_NONE,   PC_START);
      4'd7:  w = mk(ACC_MAC,    OPA_HOLD,  COEF_KI, ST_NONE,   JMP_LOOP,   PC_MAC_KI);
      4'd8:  w = mk(ACC_CLR,    OPA_PREVD, COEF_B,  ST_I,      JMP_NONE,   PC_START);
      4'd9:  w = mk(ACC_MAC,    OPA_HOLD,  COEF_AD, ST_NONE,   JMP_LOOP,   PC_MAC_AD);
      4'd10: w = mk(ACC_SHRSAT, OPA_DY,    COEF_B,  ST_NONE,   JMP_NONE,   PC_START);
      4'd11: w = mk(ACC_MAC,    OPA_HOLD,  COEF_BD, ST_NONE,   JMP_LOOP,   PC_MAC_BD);
      4'd12: w = mk(ACC_LOADP,  OPA_HOLD,  COEF_B,  ST_D,      JMP_NONE,   PC_START);
      4'd13: w = mk(ACC_ADDI,   OPA_HOLD,  COEF_B,  ST_NONE,   JMP_NONE,   PC_START);
      4'd14: w = mk(ACC_ADDD,   OPA_HOLD,  COEF_B,  ST_NONE,   JMP_NONE,   PC_START);
      4'd15: w = mk(ACC_NOP,    OPA_HOLD,  COEF_B,  ST_COMMIT, JMP_END,    PC_START);
      default: w = mk(ACC_NOP, OPA_HOLD, COEF_B, ST_NONE, JMP_END, PC_START);
    endcase
    return w;
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_term(input logic signed [TERM_W-1:0] v);
    return {{(ACC_W-TERM_W){v[TERM_W-1]}}, v};
  endfunction

  function automatic logic signed [ACC_W-1:0] ext_sample(
      input logic signed [SAMPLE_W-1:0] v);
    return {{(ACC_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

  // Clamp to the signed 48-bit term range.
  function automatic logic signed [TERM_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-TERM_W:0] top;
    top = v[ACC_W-1:TERM_W-1];
    if ((&top) || !(|top)) begin
      return v[TERM_W-1:0];
    end
    return v[ACC_W-1] ? {1'b1, {(TERM_W-1){1'b0}}} : {1'b0, {(TERM_W-1){1'b1}}};
  endfunction

  // Round half up to an integer, then clamp to the 24-bit control range.
  function automatic logic signed [CTRL_W-1:0] round_ctrl(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    logic [ACC_W-CTRL_W:0]   top;
    t   = (v + ACC_W'(32768)) >>> FRAC_W;
    top = t[ACC_W-1:CTRL_W-1];
    if ((&top) || !(|top)) begin
      return t[CTRL_W-1:0];
    end
    return t[ACC_W-1] ? {1'b1, {(CTRL_W-1){1'b0}}} : {1'b0, {(CTRL_W-1){1'b1}}};
  endfunction

endpackage

### sv/pid_regulator_filtered_derivative_core.sv
// Top level of the PID regulator with filtered derivative: configuration registers
// and handshakes. Instantiates prfd_sequencer and prfd_datapath; uses prfd_pkg.
//
// Usage: the input channel carries one sample (setpoint, measurement) per request;
// the output channel returns the control value and the error for that sample.
// Both channels use valid/stall: a request moves on an edge with valid high and
// stall low. Coefficients are written through cfg_we_i/cfg_addr_i/cfg_wdata_i
// while no sample is in flight; unknown indexes are ignored.
// With enable set, the result is valid once the whole microprogram has run for the
// accepted input; with enable clear, the first step jumps to the final one, giving
// zero outputs with the state held. One sample is processed at a time, and the next
// is taken only once the last has loaded its result. The single 49x8-bit multiplier
// steps through the three bytes of each of the five coefficient products.
// The input is accepted again the cycle after the result is loaded, even while
// that result waits; a stalled receiver holds the result and the next sample
// waits in its final step until the output register frees.
// Reset clears the regulator state to zero, clears enable and loads the
// default coefficients.
module pid_regulator_filtered_derivative_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [prfd_pkg::CFG_ADDR_W-1:0]        cfg_addr_i,
  input  logic [prfd_pkg::COEF_W-1:0]            cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [prfd_pkg::SAMPLE_W-1:0]   setpoint_i,
  input  logic signed [prfd_pkg::SAMPLE_W-1:0]   measurement_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [prfd_pkg::CTRL_W-1:0]     control_o,
  output logic signed [prfd_pkg::ERR_W-1:0]      error_o
);

  prfd_pkg::coef_t     coef_q;
  prfd_pkg::seq_ctrl_t ctrl;
  logic                busy;
  logic                start;
  logic                out_valid;
  logic                out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.enable <= 1'b0;
      coef_q.k      <= prfd_pkg::GAIN_K_RST;
      coef_q.b      <= prfd_pkg::SP_WEIGHT_RST;
      coef_q.ki     <= prfd_pkg::INT_COEF_RST;
      coef_q.ad     <= prfd_pkg::POLE_RST;
      coef_q.bd     <= prfd_pkg::D_GAIN_RST;
    end else if (cfg_we_i) begin
      case (prfd_pkg::reg_idx_e'(cfg_addr_i))
        prfd_pkg::REG_ENABLE:    coef_q.enable <= cfg_wdata_i[0];
        prfd_pkg::REG_GAIN_K:    coef_q.k      <= cfg_wdata_i;
        prfd_pkg::REG_SP_WEIGHT: coef_q.b      <= cfg_wdata_i;
        prfd_pkg::REG_INT_COEF:  coef_q.ki     <= cfg_wdata_i;
        prfd_pkg::REG_D_POLE:    coef_q.ad     <= cfg_wdata_i[prfd_pkg::POLE_W-1:0];
        prfd_pkg::REG_D_GAIN:    coef_q.bd     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign start    = in_valid_i && !busy;
  assign out_free = !out_valid || !out_stall_i;

  prfd_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .enable_i   (coef_q.enable),
    .out_free_i (out_free),
    .ctrl_o     (ctrl),
    .busy_o     (busy)
  );

  prfd_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .coef_i        (coef_q),
    .start_i       (start),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid),
    .control_o     (control_o),
    .error_o       (error_o)
  );

  assign in_stall_o  = busy;
  assign out_valid_o = out_valid;

endmodule

### sv/prfd_sequencer.sv
// Microcode sequencer: step counter, coefficient byte counter and jump logic.
// Reads the control store in prfd_pkg and drives prfd_datapath.
module prfd_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  enable_i,
  input  logic                  out_free_i,
  output prfd_pkg::seq_ctrl_t   ctrl_o,
  output logic                  busy_o
);

  logic                          busy_q, busy_d;
  logic [prfd_pkg::PC_W-1:0]     pc_q, pc_d;
  logic [prfd_pkg::DCNT_W-1:0]   digit_q, digit_d;
  prfd_pkg::uword_t              word;
  logic                          go;

  assign word = prfd_pkg::ucode(pc_q);
  // The final step waits until the output register can take the result.
  assign go   = busy_q && ((word.jmp != prfd_pkg::JMP_END) || out_free_i);

  always_comb begin
    busy_d  = busy_q;
    pc_d    = pc_q;
    digit_d = digit_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d  = 1'b1;
        pc_d    = prfd_pkg::PC_START;
        digit_d = '0;
      end
    end else if (go) begin
      case (word.jmp)
        prfd_pkg::JMP_NONE: pc_d = pc_q + prfd_pkg::PC_W'(1);
        prfd_pkg::JMP_IF_DIS: pc_d = enable_i ? pc_q + prfd_pkg::PC_W'(1) : word.target;
        prfd_pkg::JMP_LOOP: begin
          if (digit_q != prfd_pkg::LAST_DIGIT) begin
            digit_d = digit_q + prfd_pkg::DCNT_W'(1);
            pc_d    = word.target;
          end else begin
            digit_d = '0;
            pc_d    = pc_q + prfd_pkg::PC_W'(1);
          end
        end
        prfd_pkg::JMP_END: begin
          busy_d = 1'b0;
          pc_d   = prfd_pkg::PC_START;
        end
        default: busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= prfd_pkg::PC_START;
      digit_q <= '0;
    end else begin
      busy_q  <= busy_d;
      pc_q    <= pc_d;
      digit_q <= digit_d;
    end
  end

  assign ctrl_o.go    = go;
  assign ctrl_o.digit = digit_q;
  assign ctrl_o.word  = word;
  assign busy_o       = busy_q;

endmodule

### sv/prfd_datapath.sv
// Datapath of the PID regulator: byte-serial multiply-accumulate, term and state
// registers, and the output register. Controlled by prfd_sequencer; uses prfd_pkg.
module prfd_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  prfd_pkg::seq_ctrl_t                    ctrl_i,
  input  prfd_pkg::coef_t                        coef_i,
  input  logic                                   start_i,
  input  logic signed [prfd_pkg::SAMPLE_W-1:0]   setpoint_i,
  input  logic signed [prfd_pkg::SAMPLE_W-1:0]   measurement_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic signed [prfd_pkg::CTRL_W-1:0]     control_o,
  output logic signed [prfd_pkg::ERR_W-1:0]      error_o
);

  logic signed [prfd_pkg::SAMPLE_W-1:0] w_q, y_q, prev_y_q;
  logic signed [prfd_pkg::OPA_W-1:0]    opa_q, opa_d;
  logic signed [prfd_pkg::ACC_W-1:0]    acc_q, acc_d;
  logic signed [prfd_pkg::TERM_W-1:0]   p_q, i_q, d_q, isum_q, prevd_q;
  logic                                 out_valid_q;
  logic signed [prfd_pkg::CTRL_W-1:0]   control_q;
  logic signed [prfd_pkg::ERR_W-1:0]    error_q;

  logic signed [prfd_pkg::ERR_W-1:0]    err;
  logic signed [prfd_pkg::ERR_W-1:0]    dy_neg;
  logic [prfd_pkg::COEF_W-1:0]          coef;
  logic [prfd_pkg::DIGIT_W-1:0]         digit;
  logic signed [prfd_pkg::PP_W-1:0]     pp;
  logic signed [prfd_pkg::ACC_W-1:0]    pp_ext, pp_shift;
  logic                                 commit;

  assign err    = $signed({w_q[prfd_pkg::SAMPLE_W-1], w_q})
                - $signed({prev_y_q[prfd_pkg::SAMPLE_W-1], prev_y_q});
  assign dy_neg = $signed({prev_y_q[prfd_pkg::SAMPLE_W-1], prev_y_q})
                - $signed({y_q[prfd_pkg::SAMPLE_W-1], y_q});

  always_comb begin
    case (ctrl_i.word.coef_sel)
      prfd_pkg::COEF_B:  coef = coef_i.b;
      prfd_pkg::COEF_K:  coef = coef_i.k;
      prfd_pkg::COEF_KI: coef = coef_i.ki;
      prfd_pkg::COEF_AD: coef = {{(prfd_pkg::COEF_W-prfd_pkg::POLE_W){1'b0}}, coef_i.ad};
      prfd_pkg::COEF_BD: coef = coef_i.bd;
      default:           coef = '0;
    endcase
  end

  // One coefficient byte per cycle, least significant byte first.
  always_comb begin
    case (ctrl_i.digit)
      2'd0:    digit = coef[prfd_pkg::DIGIT_W-1:0];
      2'd1:    digit = coef[2*prfd_pkg::DIGIT_W-1:prfd_pkg::DIGIT_W];
      default: digit = coef[3*prfd_pkg::DIGIT_W-1:2*prfd_pkg::DIGIT_W];
    endcase
  end

  assign pp     = opa_q * $signed({1'b0, digit});
  assign pp_ext = {{(prfd_pkg::ACC_W-prfd_pkg::PP_W){pp[prfd_pkg::PP_W-1]}}, pp};

  always_comb begin
    case (ctrl_i.digit)
      2'd0:    pp_shift = pp_ext;
      2'd1:    pp_shift = pp_ext <<< prfd_pkg::DIGIT_W;
      default: pp_shift = pp_ext <<< (2 * prfd_pkg::DIGIT_W);
    endcase
  end

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.word.acc_op)
      prfd_pkg::ACC_NOP:    acc_d = acc_q;
      prfd_pkg::ACC_CLR:    acc_d = '0;
      prfd_pkg::ACC_MAC:    acc_d = acc_q + pp_shift;
      prfd_pkg::ACC_SUBY:
        acc_d = acc_q - (prfd_pkg::ext_sample(y_q) <<< prfd_pkg::FRAC_W);
      prfd_pkg::ACC_SHRSAT:
        acc_d = prfd_pkg::ext_term(prfd_pkg::sat48(acc_q >>> prfd_pkg::FRAC_W));
      prfd_pkg::ACC_LOADI:  acc_d = prfd_pkg::ext_term(isum_q);
      prfd_pkg::ACC_LOADP:  acc_d = prfd_pkg::ext_term(p_q);
      prfd_pkg::ACC_ADDI:   acc_d = acc_q + prfd_pkg::ext_term(i_q);
      prfd_pkg::ACC_ADDD:   acc_d = acc_q + prfd_pkg::ext_term(d_q);
      default:              acc_d = acc_q;
    endcase
  end

  always_comb begin
    opa_d = opa_q;
    case (ctrl_i.word.opa_src)
      prfd_pkg::OPA_HOLD:  opa_d = opa_q;
      prfd_pkg::OPA_SETP:
        opa_d = {{(prfd_pkg::OPA_W-prfd_pkg::SAMPLE_W){w_q[prfd_pkg::SAMPLE_W-1]}}, w_q};
      prfd_pkg::OPA_ACC:   opa_d = acc_q[prfd_pkg::OPA_W-1:0];
      prfd_pkg::OPA_E:
        opa_d = {{(prfd_pkg::OPA_W-prfd_pkg::ERR_W){err[prfd_pkg::ERR_W-1]}}, err};
      prfd_pkg::OPA_DY:
        opa_d = {{(prfd_pkg::OPA_W-prfd_pkg::ERR_W){dy_neg[prfd_pkg::ERR_W-1]}}, dy_neg};
      prfd_pkg::OPA_PREVD:
        opa_d = {{(prfd_pkg::OPA_W-prfd_pkg::TERM_W){prevd_q[prfd_pkg::TERM_W-1]}}, prevd_q};
      default:             opa_d = opa_q;
    endcase
  end

  assign commit = ctrl_i.go && (ctrl_i.word.store == prfd_pkg::ST_COMMIT);

  // Working registers and result payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w_q <= setpoint_i;
      y_q <= measurement_i;
    end
    if (ctrl_i.go) begin
      acc_q <= acc_d;
      opa_q <= opa_d;
      case (ctrl_i.word.store)
        prfd_pkg::ST_P: p_q <= prfd_pkg::sat48(acc_q);
        prfd_pkg::ST_I: i_q <= prfd_pkg::sat48(acc_q);
        prfd_pkg::ST_D: d_q <= prfd_pkg::sat48(acc_q);
        default: ;
      endcase
    end
    if (commit) begin
      if (coef_i.enable) begin
        control_q <= prfd_pkg::round_ctrl(acc_q);
        error_q   <= err;
      end else begin
        control_q <= '0;
        error_q   <= '0;
      end
    end
  end

  // Regulator state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_y_q    <= '0;
      isum_q      <= '0;
      prevd_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
        if (coef_i.enable) begin
          prev_y_q <= y_q;
          isum_q   <= i_q;
          prevd_q  <= d_q;
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign control_o   = control_q;
  assign error_o     = error_q;

endmodule

### sv/prfd_checker.sv
// Port-level checker for the PID regulator core, bound to the top level.
// Uses the assertion macros of pid_regulator_filtered_derivative_core_assert.svh.
`include "pid_regulator_filtered_derivative_core_assert.svh"

module prfd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [prfd_pkg::CTRL_W-1:0]   control_o,
  input logic signed [prfd_pkg::ERR_W-1:0]    error_o
);

  // An accepted sample keeps the block busy on the following cycle.
  `PRFD_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // No result can appear on the edge right after a sample is accepted.
  `PRFD_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  // A new result is only loaded when its sample finishes, freeing the input.
  `PRFD_ASSERT_IMPLY(a_done_frees_input, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

  // A stalled result stays valid and unchanged.
  `PRFD_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(control_o) && $stable(error_o))

endmodule

bind pid_regulator_filtered_derivative_core prfd_checker u_prfd_checker (.*);

### tb/tb_top.sv
// Self-checking testbench of the PID regulator core with filtered derivative.
// Drives samples and coefficient writes, predicts each result and checks it in order.
// Depends on prfd_pkg and pid_regulator_filtered_derivative_core.
module tb_top;
  import prfd_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic signed [CTRL_W-1:0] control;
    logic signed [ERR_W-1:0]  error;
  } pid_result_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [CFG_ADDR_W-1:0]      idx;
    logic [COEF_W-1:0]          value;
    logic signed [SAMPLE_W-1:0] setpoint;
    logic signed [SAMPLE_W-1:0] measurement;
    logic                       typed;
    pid_result_t                want;
  } stim_row_t;

  typedef enum logic [1:0] {MODE_SPREAD, MODE_TRACK, MODE_WINDUP} drive_mode_e;

  localparam wide_t TERM_HI  = 96'sh7FFF_FFFF_FFFF;
  localparam wide_t TERM_LO  = -96'sh8000_0000_0000;
  localparam wide_t CTRL_HI  = 96'sd8388607;
  localparam wide_t CTRL_LO  = -96'sd8388608;
  localparam wide_t HALF_LSB = 96'sd32768;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Indexes past the last register; writes to them must be ignored.
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int IDLE_PCT       = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 40;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_ADDR_W-1:0]      cfg_addr_i;
  logic [COEF_W-1:0]          cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] setpoint_i;
  logic signed [SAMPLE_W-1:0] measurement_i;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic signed [CTRL_W-1:0]   control_o;
  logic signed [ERR_W-1:0]    error_o;

  pid_regulator_filtered_derivative_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .setpoint_i    (setpoint_i),
    .measurement_i (measurement_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .control_o     (control_o),
    .error_o       (error_o)
  );

  // Predictor copy of the registers and of the regulator state.
  logic                       pid_enable = 1'b0;
  logic [COEF_W-1:0]          pid_k  = GAIN_K_RST;
  logic [COEF_W-1:0]          pid_b  = SP_WEIGHT_RST;
  logic [COEF_W-1:0]          pid_ki = INT_COEF_RST;
  logic [POLE_W-1:0]          pid_pole = POLE_RST;
  logic [COEF_W-1:0]          pid_bd = D_GAIN_RST;
  logic signed [SAMPLE_W-1:0] pid_prev_y = '0;
  logic signed [TERM_W-1:0]   pid_integral = '0;
  logic signed [TERM_W-1:0]   pid_prev_deriv = '0;

  pid_result_t expected_q[$];
  stim_row_t   plan[$];
  logic [CFG_ADDR_W-1:0] coef_regs [5];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  bit          no_idle = 1'b0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic signed [TERM_W-1:0] sat_term(input wide_t v);
    if (v > TERM_HI) return TERM_HI[TERM_W-1:0];
    if (v < TERM_LO) return TERM_LO[TERM_W-1:0];
    return v[TERM_W-1:0];
  endfunction

  // Q.16 value times a Q8.16 coefficient, floored back to Q.16 and clamped.
  function automatic logic signed [TERM_W-1:0] scale_q16(input wide_t a,
                                                         input logic [COEF_W-1:0] c);
    wide_t c_x;
    wide_t prod;
    c_x  = {72'd0, c};
    prod = a * c_x;
    return sat_term(prod >>> FRAC_W);
  endfunction

  task automatic pid_step(input logic signed [SAMPLE_W-1:0] w,
                          input logic signed [SAMPLE_W-1:0] y,
                          output pid_result_t res);
    wide_t w_x, y_x, py_x, e_x, inner, p_t, i_t, d_t, u_t, r_t;
    wide_t b_x, ki_x, bd_x, integ_x, prevd_x;
    res = '0;
    if (pid_enable) begin
      w_x     = w;
      y_x     = y;
      py_x    = pid_prev_y;
      b_x     = {72'd0, pid_b};
      ki_x    = {72'd0, pid_ki};
      bd_x    = {72'd0, pid_bd};
      integ_x = pid_integral;
      prevd_x = pid_prev_deriv;
      e_x     = w_x - py_x;
      inner   = w_x * b_x - (y_x <<< FRAC_W);
      p_t     = scale_q16(inner, pid_k);
      i_t     = sat_term(integ_x + e_x * ki_x);
      d_t     = sat_term(scale_q16(prevd_x, {7'd0, pid_pole}) - (y_x - py_x) * bd_x);
      u_t     = p_t + i_t + d_t;
      r_t     = (u_t + HALF_LSB) >>> FRAC_W;
      if (r_t > CTRL_HI) r_t = CTRL_HI;
      if (r_t < CTRL_LO) r_t = CTRL_LO;
      res.control    = r_t[CTRL_W-1:0];
      res.error      = e_x[ERR_W-1:0];
      pid_integral   = i_t[TERM_W-1:0];
      pid_prev_deriv = d_t[TERM_W-1:0];
      pid_prev_y     = y;
    end
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [COEF_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_ENABLE:    pid_enable = value[0];
      REG_GAIN_K:    pid_k      = value;
      REG_SP_WEIGHT: pid_b      = value;
      REG_INT_COEF:  pid_ki     = value;
      REG_D_POLE:    pid_pole   = value[POLE_W-1:0];
      REG_D_GAIN:    pid_bd     = value;
      default: ;
    endcase
  endtask

  // Returns at the edge that accepted the request, with valid still high.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] w,
                             input logic signed [SAMPLE_W-1:0] y,
                             input logic typed, input pid_result_t typed_res);
    pid_result_t res;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    setpoint_i    <= w;
    measurement_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pid_step(w, y, res);
    expected_q.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic stim_row_t write_row(input logic [CFG_ADDR_W-1:0] idx,
                                          input logic [COEF_W-1:0] value);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t sample_row(input int w, input int y, input logic typed,
                                           input int c, input int e);
    stim_row_t r;
    r              = '0;
    r.kind         = ROW_SAMPLE;
    r.setpoint     = w[SAMPLE_W-1:0];
    r.measurement  = y[SAMPLE_W-1:0];
    r.typed        = typed;
    r.want.control = c[CTRL_W-1:0];
    r.want.error   = e[ERR_W-1:0];
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] draw_value(input logic [CFG_ADDR_W-1:0] idx);
    logic [COEF_W-1:0] v;
    if (idx == REG_D_POLE) begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = 24'd65536;
        2:       v = 24'h01FFFF;
        3:       v = 24'($urandom);
        default: v = 24'($urandom_range(0, 65536));
      endcase
    end else begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        2, 3, 4: v = 24'($urandom_range(0, 131072));
        default: v = 24'($urandom);
      endcase
    end
    return v;
  endfunction

  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    pid_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual control %0d error %0d",
                   $time, control_o, error_o);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (control_o !== want.control) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: control mismatch: expected %0d, actual %0d",
                     $time, want.control, control_o);
          fail_count++;
        end
        if (error_o !== want.error) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: error mismatch: expected %0d, actual %0d",
                     $time, want.error, error_o);
          fail_count++;
        end
      end
    end
  end

  // Counts cycles in which neither channel moves a request.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t             row;
    pid_result_t           none;
    drive_mode_e           mode;
    logic signed [SAMPLE_W-1:0] w, y;
    logic [CFG_ADDR_W-1:0] spare;
    bit                    windup_hi;
    int                    sent, len, tgt, phase;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    setpoint_i    = '0;
    measurement_i = '0;
    none          = '0;
    coef_regs     = '{REG_GAIN_K, REG_SP_WEIGHT, REG_INT_COEF, REG_D_POLE, REG_D_GAIN};

    // The block comes out of reset disabled, so any sample gives zeros.
    plan.push_back(sample_row(32767, -32768, 1'b1, 0, 0));
    plan.push_back(sample_row(-32768, 32767, 1'b1, 0, 0));
    plan.push_back(write_row(REG_ENABLE, 24'h000001));
    plan.push_back(sample_row(0, 0, 1'b1, 0, 0));
    plan.push_back(sample_row(100, 40, 1'b0, 0, 0));
    plan.push_back(sample_row(-100, -40, 1'b0, 0, 0));
    plan.push_back(sample_row(-1, 1, 1'b0, 0, 0));
    // Only bit 0 of the enable register counts; the state is held while disabled.
    plan.push_back(write_row(REG_ENABLE, 24'hFFFFFE));
    plan.push_back(sample_row(1234, -999, 1'b1, 0, 0));
    plan.push_back(write_row(REG_ENABLE, 24'hFFFFFF));
    plan.push_back(write_row(REG_SPARE_6, 24'hFFFFFF));
    plan.push_back(write_row(REG_SPARE_7, 24'h000000));
    plan.push_back(sample_row(5, 5, 1'b0, 0, 0));
    plan.push_back(sample_row(0, 0, 1'b0, 0, 0));
    // Largest coefficients drive the output into both rails.
    plan.push_back(write_row(REG_GAIN_K, 24'hFFFFFF));
    plan.push_back(write_row(REG_SP_WEIGHT, 24'hFFFFFF));
    plan.push_back(write_row(REG_INT_COEF, 24'hFFFFFF));
    plan.push_back(write_row(REG_D_POLE, 24'h010000));
    plan.push_back(write_row(REG_D_GAIN, 24'hFFFFFF));
    plan.push_back(sample_row(32767, -32768, 1'b1, 8388607, 32767));
    plan.push_back(sample_row(-32768, 32767, 1'b1, -8388608, 0));
    plan.push_back(sample_row(-32768, -32768, 1'b0, 0, 0));
    plan.push_back(sample_row(32767, 0, 1'b0, 0, 0));
    // A pole above one makes the derivative grow until it clamps.
    plan.push_back(write_row(REG_D_POLE, 24'h01FFFF));
    plan.push_back(sample_row(0, 32767, 1'b0, 0, 0));
    plan.push_back(sample_row(0, -32768, 1'b0, 0, 0));
    plan.push_back(sample_row(0, 32767, 1'b0, 0, 0));
    plan.push_back(write_row(REG_D_POLE, 24'hFFFFFF));
    plan.push_back(sample_row(0, -32768, 1'b0, 0, 0));
    plan.push_back(write_row(REG_GAIN_K, 24'h000000));
    plan.push_back(write_row(REG_SP_WEIGHT, 24'h000000));
    plan.push_back(write_row(REG_INT_COEF, 24'h000000));
    plan.push_back(write_row(REG_D_POLE, 24'h000000));
    plan.push_back(write_row(REG_D_GAIN, 24'h000000));
    plan.push_back(sample_row(-32768, 32767, 1'b0, 0, 0));
    plan.push_back(write_row(REG_GAIN_K, GAIN_K_RST));
    plan.push_back(write_row(REG_SP_WEIGHT, SP_WEIGHT_RST));
    plan.push_back(write_row(REG_INT_COEF, INT_COEF_RST));
    plan.push_back(write_row(REG_D_POLE, {7'd0, POLE_RST}));
    plan.push_back(write_row(REG_D_GAIN, D_GAIN_RST));
    plan.push_back(sample_row(1, 2, 1'b0, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < plan.size(); n++) begin
      row = plan[n];
      if (row.kind == ROW_WRITE) begin
        if (n == 0 || plan[n-1].kind != ROW_WRITE) wait_drained();
        write_reg(row.idx, row.value);
        if (n + 1 == plan.size() || plan[n+1].kind != ROW_WRITE) cfg_we_i <= 1'b0;
      end else begin
        send_sample(row.setpoint, row.measurement, row.typed, row.want);
      end
    end

    sent = 0;
    tgt = 0;
    for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
      wait_drained();
      no_idle   = (phase == 5) || (phase == 6);
      mode      = drive_mode_e'($urandom_range(0, 2));
      windup_hi = $urandom_range(0, 1);
      write_reg(REG_ENABLE, {23'($urandom),
                             (mode == MODE_WINDUP) || ($urandom_range(0, 7) != 0)});
      foreach (coef_regs[r]) begin
        if ($urandom_range(0, 1)) write_reg(coef_regs[r], draw_value(coef_regs[r]));
      end
      if ($urandom_range(0, 7) == 0) begin
        spare = $urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7;
        write_reg(spare, 24'($urandom));
      end
      // A steady large error with the largest integral gain winds the integrator up.
      if (mode == MODE_WINDUP) write_reg(REG_INT_COEF, 24'hFFFFFF);
      cfg_we_i <= 1'b0;

      len = (mode == MODE_WINDUP) ? 200 : $urandom_range(20, 150);
      tgt = int'($urandom_range(0, 60000)) - 30000;
      repeat (len) begin
        case (mode)
          MODE_TRACK: begin
            if ($urandom_range(0, 15) == 0) tgt = int'($urandom_range(0, 60000)) - 30000;
            w = 16'(tgt);
            y = 16'(tgt + int'($urandom_range(0, 256)) - 128);
          end
          MODE_WINDUP: begin
            w = windup_hi ? SAMPLE_MAX : SAMPLE_MIN;
            y = windup_hi ? SAMPLE_MIN : SAMPLE_MAX;
            if ($urandom_range(0, 9) == 0) y = 16'($urandom);
          end
          default: begin
            w = 16'($urandom);
            y = 16'($urandom);
          end
        endcase
        send_sample(w, y, 1'b0, none);
        sent++;
        if ($urandom_range(0, 249) == 0) wait_drained();
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/prfd_pkg.sv
sv/prfd_sequencer.sv
sv/prfd_datapath.sv
sv/pid_regulator_filtered_derivative_core.sv
sv/prfd_checker.sv
tb/tb_top.sv
